// File: hdl/pmb_pkg.sv
// shared types, constants and helper functions for the pixel merge blend pipeline
`timescale 1ns / 1ps
`default_nettype none

package pmb_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int MIX_FRAC   = 12;

    localparam int EXT_W   = DATA_WIDTH + 1;        // one bit of headroom for differences
    localparam int SAT_W   = 2 * DATA_WIDTH + 2;    // products and sums before saturation
    localparam int K_W     = FRAC_BITS + 1;         // coverage and weight, 0 .. one
    localparam int MIX_W   = MIX_FRAC + 1;          // mix register
    localparam int CFG_W   = MIX_W;                 // widest register
    localparam int CFG_IDX_W = 2;
    localparam int WP_W    = MIX_W + K_W;           // mix times coverage

    localparam logic signed [EXT_W-1:0] ONE_D   = EXT_W'(1 << FRAC_BITS);
    localparam logic signed [SAT_W-1:0] ONE_S   = SAT_W'(1 << FRAC_BITS);
    localparam logic signed [SAT_W-1:0] HALF_S  = SAT_W'(1 << (FRAC_BITS - 1));
    localparam logic [K_W-1:0]          ONE_K   = K_W'(1 << FRAC_BITS);
    localparam logic [MIX_W-1:0]        ONE_MIX = MIX_W'(1 << MIX_FRAC);
    localparam logic [WP_W-1:0]         HALF_MIX = WP_W'(1 << (MIX_FRAC - 1));
    localparam logic signed [SAT_W-1:0] WORD_MAX = SAT_W'((1 << (DATA_WIDTH - 1)) - 1);
    localparam logic signed [SAT_W-1:0] WORD_MIN = ~WORD_MAX;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [EXT_W-1:0]      t_diff;
    typedef logic [SAT_W-1:0]      t_prod;
    typedef logic [K_W-1:0]        t_cov;

    typedef enum logic [2:0] {
        OP_OVER   = 3'd0,
        OP_PLUS   = 3'd1,
        OP_MUL    = 3'd2,
        OP_SCREEN = 3'd3,
        OP_DIFF   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        MSK_NONE  = 3'd0,
        MSK_RED   = 3'd1,
        MSK_GREEN = 3'd2,
        MSK_BLUE  = 3'd3,
        MSK_ALPHA = 3'd4
    } t_mask_sel;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPERATION    = 2'd0,
        REG_MIX          = 2'd1,
        REG_MASK_CHANNEL = 2'd2,
        REG_INVERT_MASK  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]       op;
        logic [MIX_W-1:0] mix;
        logic [2:0]       msel;
        logic             inv;
    } t_cfg;

    // after the target stages: background, foreground alpha, target minus background
    typedef struct packed {
        t_word [3:0] bg;
        t_word       alpha;
        t_diff [2:0] diff;
    } t_tgt;

    // after the composite stages: background, composite minus background, weight
    typedef struct packed {
        t_word [3:0] bg;
        t_diff [3:0] delta;
        t_cov        w;
    } t_cmp;

    function automatic logic signed [EXT_W-1:0] ext_d(input t_word x);
        return {x[DATA_WIDTH-1], x};
    endfunction

    function automatic logic signed [SAT_W-1:0] ext_s(input t_word x);
        return {{(SAT_W - DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
    endfunction

    function automatic t_word sat_word(input logic signed [SAT_W-1:0] x);
        t_word r;
        if (x > WORD_MAX) begin
            r = WORD_MAX[DATA_WIDTH-1:0];
        end else if (x < WORD_MIN) begin
            r = WORD_MIN[DATA_WIDTH-1:0];
        end else begin
            r = x[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pmb_target.sv
// stages one and two: blend mode target per colour channel, minus background
`timescale 1ns / 1ps
`default_nettype none

module pmb_target import pmb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [2:0]  i_op,
    input  t_word [3:0] i_bg,
    input  t_word [3:0] i_fg,
    output logic        o_valid,
    output t_tgt        o_tgt
);

    logic        r1_valid;
    logic [2:0]  r1_op;
    t_word [3:0] r1_bg;
    t_word [3:0] r1_fg;
    t_prod [2:0] r1_prod;
    t_prod [2:0] n1_prod;

    logic        r2_valid;
    t_tgt        r2_tgt;
    t_tgt        n2_tgt;

    // multiply or screen product, one multiplier per channel
    always_comb begin
        logic signed [EXT_W-1:0] ma;
        logic signed [EXT_W-1:0] mb;
        logic signed [SAT_W-1:0] p;
        for (int c = 0; c < 3; c++) begin
            if (i_op == OP_SCREEN) begin
                ma = ONE_D - ext_d(i_bg[c]);
                mb = ONE_D - ext_d(i_fg[c]);
            end else begin
                ma = ext_d(i_bg[c]);
                mb = ext_d(i_fg[c]);
            end
            p = ma * mb;
            n1_prod[c] = p;
        end
    end

    // target by mode, saturated, then target minus background
    always_comb begin
        logic signed [SAT_W-1:0] b;
        logic signed [SAT_W-1:0] f;
        logic signed [SAT_W-1:0] rnd;
        logic signed [SAT_W-1:0] t;
        t_word                   tw;
        n2_tgt.bg    = r1_bg;
        n2_tgt.alpha = r1_fg[3];
        for (int c = 0; c < 3; c++) begin
            b   = ext_s(r1_bg[c]);
            f   = ext_s(r1_fg[c]);
            rnd = ($signed(r1_prod[c]) + HALF_S) >>> FRAC_BITS;
            case (r1_op)
                OP_PLUS:   t = b + f;
                OP_MUL:    t = rnd;
                OP_SCREEN: t = ONE_S - rnd;
                OP_DIFF:   t = (b >= f) ? (b - f) : (f - b);
                default:   t = f;
            endcase
            tw = sat_word(t);
            n2_tgt.diff[c] = ext_d(tw) - ext_d(r1_bg[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_op   <= i_op;
        r1_bg   <= i_bg;
        r1_fg   <= i_fg;
        r1_prod <= n1_prod;
        r2_tgt  <= n2_tgt;
    end

    assign o_valid = r2_valid;
    assign o_tgt   = r2_tgt;

endmodule

`default_nettype wire

// File: hdl/pmb_cover.sv
// stages one and two: mask coverage and the mix weight
`timescale 1ns / 1ps
`default_nettype none

module pmb_cover import pmb_pkg::*; (
    input  logic        i_clk,
    input  t_cfg        i_cfg,
    input  t_word [3:0] i_mask,
    output t_cov        o_w
);

    t_cov             r_k;
    t_cov             n_k;
    logic [MIX_W-1:0] r_mx;
    logic [MIX_W-1:0] n_mx;
    t_cov             r_w;
    t_cov             n_w;

    always_comb begin
        logic signed [EXT_W-1:0] kv;
        t_word                   m;
        logic                    sel;
        sel = 1'b1;
        m   = i_mask[3];
        case (i_cfg.msel)
            MSK_RED:   m = i_mask[0];
            MSK_GREEN: m = i_mask[1];
            MSK_BLUE:  m = i_mask[2];
            MSK_ALPHA: m = i_mask[3];
            default:   sel = 1'b0;
        endcase
        kv = ext_d(m);
        if (i_cfg.inv) begin
            kv = ONE_D - kv;
        end
        // clamp to 0 .. one
        if (!sel) begin
            n_k = ONE_K;
        end else if (kv[EXT_W-1]) begin
            n_k = '0;
        end else if (kv > ONE_D) begin
            n_k = ONE_K;
        end else begin
            n_k = kv[K_W-1:0];
        end
        n_mx = (i_cfg.mix > ONE_MIX) ? ONE_MIX : i_cfg.mix;
    end

    always_comb begin
        logic [WP_W-1:0] p;
        p   = r_mx * r_k;
        p   = (p + HALF_MIX) >> MIX_FRAC;
        n_w = p[K_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_k  <= n_k;
        r_mx <= n_mx;
        r_w  <= n_w;
    end

    assign o_w = r_w;

endmodule

`default_nettype wire

// File: hdl/pmb_comp.sv
// stages three and four: composite per channel and composite alpha
`timescale 1ns / 1ps
`default_nettype none

module pmb_comp import pmb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_tgt i_tgt,
    input  t_cov i_w,
    output logic o_valid,
    output t_cmp o_cmp
);

    logic        r3_valid;
    t_prod [3:0] r3_prod;
    t_prod [3:0] n3_prod;
    t_word [3:0] r3_bg;
    t_word       r3_alpha;
    t_cov        r3_w;

    logic        r4_valid;
    t_cmp        r4_cmp;
    t_cmp        n4_cmp;

    // colour: alpha times (target - bg); alpha: (one - alpha) times bg alpha
    always_comb begin
        logic signed [EXT_W-1:0] ma;
        logic signed [EXT_W-1:0] mb;
        logic signed [SAT_W-1:0] p;
        for (int c = 0; c < 4; c++) begin
            if (c < 3) begin
                ma = $signed(i_tgt.diff[c]);
                mb = ext_d(i_tgt.alpha);
            end else begin
                ma = ONE_D - ext_d(i_tgt.alpha);
                mb = ext_d(i_tgt.bg[3]);
            end
            p = ma * mb;
            n3_prod[c] = p;
        end
    end

    always_comb begin
        logic signed [SAT_W-1:0] rnd;
        logic signed [SAT_W-1:0] base;
        t_word                   cw;
        n4_cmp.bg = r3_bg;
        n4_cmp.w  = r3_w;
        for (int c = 0; c < 4; c++) begin
            rnd  = ($signed(r3_prod[c]) + HALF_S) >>> FRAC_BITS;
            base = (c < 3) ? ext_s(r3_bg[c]) : ext_s(r3_alpha);
            cw   = sat_word(base + rnd);
            n4_cmp.delta[c] = ext_d(cw) - ext_d(r3_bg[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_prod  <= n3_prod;
        r3_bg    <= i_tgt.bg;
        r3_alpha <= i_tgt.alpha;
        r3_w     <= i_w;
        r4_cmp   <= n4_cmp;
    end

    assign o_valid = r4_valid;
    assign o_cmp   = r4_cmp;

endmodule

`default_nettype wire

// File: hdl/pmb_mix.sv
// stages five and six: lerp from background toward composite by the weight
`timescale 1ns / 1ps
`default_nettype none

module pmb_mix import pmb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmp        i_cmp,
    output logic        o_valid,
    output t_word [3:0] o_pix
);

    logic        r5_valid;
    t_prod [3:0] r5_prod;
    t_prod [3:0] n5_prod;
    t_word [3:0] r5_bg;

    logic        r6_valid;
    t_word [3:0] r6_pix;
    t_word [3:0] n6_pix;

    always_comb begin
        logic signed [SAT_W-1:0] p;
        for (int c = 0; c < 4; c++) begin
            p = $signed({1'b0, i_cmp.w}) * $signed(i_cmp.delta[c]);
            n5_prod[c] = p;
        end
    end

    always_comb begin
        logic signed [SAT_W-1:0] rnd;
        for (int c = 0; c < 4; c++) begin
            rnd       = ($signed(r5_prod[c]) + HALF_S) >>> FRAC_BITS;
            n6_pix[c] = sat_word(ext_s(r5_bg[c]) + rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r5_valid <= i_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_prod <= n5_prod;
        r5_bg   <= i_cmp.bg;
        r6_pix  <= n6_pix;
    end

    assign o_valid = r6_valid;
    assign o_pix   = r6_pix;

endmodule

`default_nettype wire

// File: hdl/pixel_merge_blend.sv
// top level of the pixel merge blend compositor: config registers and the six stage pipeline
//
//  channel   signals                                   handshake
//  -------   ---------------------------------------   ----------------------------------
//  input     i_bg_*, i_fg_*, i_mask_* (16 b signed)    word taken when start & !busy
//  result    o_out_* (16 b signed)                     o_strobe high for one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata          written when i_cfg_we, no wait
//
//  one word in and one word out per clock; six register stages, each holding one multiplier
//  or one rounding add and saturation
//  busy is always low: the pipeline never stalls, as the receiver cannot hold results off
//  synchronous active-low reset clears the valid bits and sets the registers to
//  over, full mix, alpha mask, no inversion
//  config is read live by the first stage, so change it only with the pipeline empty
`timescale 1ns / 1ps
`default_nettype none

module pixel_merge_blend import pmb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic [DATA_WIDTH-1:0] i_bg_red,
    input  logic [DATA_WIDTH-1:0] i_bg_green,
    input  logic [DATA_WIDTH-1:0] i_bg_blue,
    input  logic [DATA_WIDTH-1:0] i_bg_alpha,
    input  logic [DATA_WIDTH-1:0] i_fg_red,
    input  logic [DATA_WIDTH-1:0] i_fg_green,
    input  logic [DATA_WIDTH-1:0] i_fg_blue,
    input  logic [DATA_WIDTH-1:0] i_fg_alpha,
    input  logic [DATA_WIDTH-1:0] i_mask_red,
    input  logic [DATA_WIDTH-1:0] i_mask_green,
    input  logic [DATA_WIDTH-1:0] i_mask_blue,
    input  logic [DATA_WIDTH-1:0] i_mask_alpha,
    output logic                 o_strobe,
    output logic [DATA_WIDTH-1:0] o_out_red,
    output logic [DATA_WIDTH-1:0] o_out_green,
    output logic [DATA_WIDTH-1:0] o_out_blue,
    output logic [DATA_WIDTH-1:0] o_out_alpha
);

    // config registers
    t_cfg r_cfg;

    // words packed red, green, blue, alpha from index 0
    t_word [3:0] bg;
    t_word [3:0] fg;
    t_word [3:0] mask;
    logic        accept;

    logic        tgt_valid;
    t_tgt        tgt;
    t_cov        w;
    logic        cmp_valid;
    t_cmp        cmp;
    t_word [3:0] pix;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign bg   = {i_bg_alpha, i_bg_blue, i_bg_green, i_bg_red};
    assign fg   = {i_fg_alpha, i_fg_blue, i_fg_green, i_fg_red};
    assign mask = {i_mask_alpha, i_mask_blue, i_mask_green, i_mask_red};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.op   <= OP_OVER;
            r_cfg.mix  <= ONE_MIX;
            r_cfg.msel <= MSK_ALPHA;
            r_cfg.inv  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OPERATION:    r_cfg.op   <= i_cfg_wdata[2:0];
                REG_MIX:          r_cfg.mix  <= i_cfg_wdata[MIX_W-1:0];
                REG_MASK_CHANNEL: r_cfg.msel <= i_cfg_wdata[2:0];
                REG_INVERT_MASK:  r_cfg.inv  <= i_cfg_wdata[0];
                default:          r_cfg      <= r_cfg;
            endcase
        end
    end

    // stages one and two: mode target, target minus background
    pmb_target u_target (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_op    (r_cfg.op),
        .i_bg    (bg),
        .i_fg    (fg),
        .o_valid (tgt_valid),
        .o_tgt   (tgt)
    );

    // stages one and two in parallel: coverage, then mix times coverage
    pmb_cover u_cover (
        .i_clk  (i_clk),
        .i_cfg  (r_cfg),
        .i_mask (mask),
        .o_w    (w)
    );

    // stages three and four: composite colour and alpha, minus background
    pmb_comp u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tgt_valid),
        .i_tgt   (tgt),
        .i_w     (w),
        .o_valid (cmp_valid),
        .o_cmp   (cmp)
    );

    // stages five and six: weighted lerp and output register
    pmb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cmp_valid),
        .i_cmp   (cmp),
        .o_valid (o_strobe),
        .o_pix   (pix)
    );

    assign o_out_red   = pix[0];
    assign o_out_green = pix[1];
    assign o_out_blue  = pix[2];
    assign o_out_alpha = pix[3];

endmodule

`default_nettype wire

// File: verif/tb_pixel_merge_blend.sv
// testbench for pixel_merge_blend: directed pixel table and random phases checked by a blend predictor
`timescale 1ns / 1ps

module tb_pixel_merge_blend;
    import pmb_pkg::*;

    // pipeline depth from the accepting edge to the edge that takes the result
    localparam int PIPE_LAT  = 6;
    localparam int N_PHASES  = 12;

    // operation and mask codes beyond the named ones
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    localparam logic [2:0] MSK_SPARE_LO = 3'd5;
    localparam logic [2:0] MSK_SPARE_HI = 3'd7;
    localparam logic [MIX_W-1:0] MIX_TOP = '1;

    localparam longint ONE_Q = longint'(1) <<< FRAC_BITS;
    localparam longint W_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint W_MIN = -W_MAX - 1;

    // register state after reset, and the same with full coverage
    localparam t_cfg CFG_RESET = '{OP_OVER, ONE_MIX, MSK_ALPHA, 1'b0};
    localparam t_cfg CFG_FULL  = '{OP_OVER, ONE_MIX, MSK_NONE, 1'b0};

    typedef struct packed {
        t_word r;
        t_word g;
        t_word b;
        t_word a;
    } t_rgba;

    typedef struct packed {
        t_rgba bg;
        t_rgba fg;
        t_rgba mk;
    } t_pix_in;

    typedef struct {
        t_cfg    cfg;
        t_pix_in px;
        bit      pinned;
        t_rgba   want;
    } t_pix_case;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;
    t_pix_in               drive_px = '0;
    logic                  o_strobe;
    logic [DATA_WIDTH-1:0] o_out_red;
    logic [DATA_WIDTH-1:0] o_out_green;
    logic [DATA_WIDTH-1:0] o_out_blue;
    logic [DATA_WIDTH-1:0] o_out_alpha;

    // a word carrying its own typed-in result instead of the predicted one
    bit    pinned_en = 1'b0;
    t_rgba pinned_val = '0;

    t_rgba     composite_due[$];
    t_pix_case directed_cases[$];
    t_cfg      live_cfg = CFG_RESET;
    int        n_bad_words = 0;

    always #1 i_clk = ~i_clk;

    pixel_merge_blend i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_bg_red     (drive_px.bg.r),
        .i_bg_green   (drive_px.bg.g),
        .i_bg_blue    (drive_px.bg.b),
        .i_bg_alpha   (drive_px.bg.a),
        .i_fg_red     (drive_px.fg.r),
        .i_fg_green   (drive_px.fg.g),
        .i_fg_blue    (drive_px.fg.b),
        .i_fg_alpha   (drive_px.fg.a),
        .i_mask_red   (drive_px.mk.r),
        .i_mask_green (drive_px.mk.g),
        .i_mask_blue  (drive_px.mk.b),
        .i_mask_alpha (drive_px.mk.a),
        .o_strobe     (o_strobe),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_out_alpha  (o_out_alpha)
    );

    // ------------------------------------------------------------------
    // blend predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_word(longint x);
        if (x > W_MAX) begin
            return W_MAX;
        end
        if (x < W_MIN) begin
            return W_MIN;
        end
        return x;
    endfunction

    // rescale a product: add half, then floor
    function automatic longint round_q(longint x, int sh);
        return (x + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint chan(t_rgba p, int idx);
        case (idx)
            0: return longint'(signed'(p.r));
            1: return longint'(signed'(p.g));
            2: return longint'(signed'(p.b));
            default: return longint'(signed'(p.a));
        endcase
    endfunction

    function automatic t_rgba blend_pixel(t_pix_in px, t_cfg c);
        longint bg[4];
        longint fg[4];
        longint comp[4];
        longint res[4];
        longint a, t, k, w, mx;
        t_rgba  out_px;
        for (int i = 0; i < 4; i++) begin
            bg[i] = chan(px.bg, i);
            fg[i] = chan(px.fg, i);
        end
        a = fg[3];
        // per channel target, saturated before the foreground alpha lerp
        for (int i = 0; i < 3; i++) begin
            case (c.op)
                OP_PLUS:   t = bg[i] + fg[i];
                OP_MUL:    t = round_q(bg[i] * fg[i], FRAC_BITS);
                OP_SCREEN: t = ONE_Q - round_q((ONE_Q - bg[i]) * (ONE_Q - fg[i]), FRAC_BITS);
                OP_DIFF:   t = (bg[i] >= fg[i]) ? bg[i] - fg[i] : fg[i] - bg[i];
                default:   t = fg[i];
            endcase
            t = clamp_word(t);
            comp[i] = clamp_word(bg[i] + round_q(a * (t - bg[i]), FRAC_BITS));
        end
        comp[3] = clamp_word(a + round_q((ONE_Q - a) * bg[3], FRAC_BITS));
        // coverage from the chosen mask channel, clamped after inversion
        if (c.msel >= MSK_RED && c.msel <= MSK_ALPHA) begin
            k = chan(px.mk, int'(c.msel) - 1);
            if (c.inv) begin
                k = ONE_Q - k;
            end
            if (k < 0) begin
                k = 0;
            end
            if (k > ONE_Q) begin
                k = ONE_Q;
            end
        end else begin
            k = ONE_Q;
        end
        mx = (c.mix > ONE_MIX) ? longint'(ONE_MIX) : longint'(c.mix);
        w = round_q(mx * k, MIX_FRAC);
        for (int i = 0; i < 4; i++) begin
            res[i] = clamp_word(bg[i] + round_q(w * (comp[i] - bg[i]), FRAC_BITS));
        end
        out_px.r = t_word'(res[0]);
        out_px.g = t_word'(res[1]);
        out_px.b = t_word'(res[2]);
        out_px.a = t_word'(res[3]);
        return out_px;
    endfunction

    // ------------------------------------------------------------------
    // random stimulus
    // ------------------------------------------------------------------

    // mostly full range, plus plenty inside 0..one where coverage and alpha live
    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_word'($urandom);
            4, 5, 6:    return t_word'($urandom_range(0, 4096));
            7:          return t_word'(4064 + $urandom_range(0, 64));
            8:          return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default:    return t_word'(-int'($urandom_range(1, 512)));
        endcase
    endfunction

    function automatic t_pix_in rand_pixel();
        return {rand_word(), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // first phases pin the extremes, the rest are drawn at random
    function automatic t_cfg phase_setting(int n);
        t_cfg c;
        case (n)
            0: c = CFG_RESET;
            1: c = '{OP_PLUS, '0, MSK_NONE, 1'b0};
            2: c = '{OP_MUL, MIX_TOP, MSK_RED, 1'b1};
            3: c = '{OP_SCREEN, ONE_MIX, MSK_GREEN, 1'b0};
            4: c = '{OP_DIFF, MIX_W'(2048), MSK_BLUE, 1'b1};
            5: c = '{OP_SPARE_HI, MIX_W'(4095), MSK_SPARE_LO, 1'b0};
            default: begin
                c.op = 3'($urandom_range(0, 7));
                case ($urandom_range(0, 3))
                    0: c.mix = '0;
                    1: c.mix = ONE_MIX;
                    2: c.mix = MIX_W'($urandom_range(0, 4096));
                    default: c.mix = MIX_W'($urandom);
                endcase
                c.msel = 3'($urandom_range(0, 7));
                c.inv = 1'($urandom_range(0, 1));
            end
        endcase
        return c;
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // driver tasks, all but add_case called just after a rising edge
    // ------------------------------------------------------------------

    task automatic add_case(input t_cfg c, input t_rgba bg, input t_rgba fg, input t_rgba mk,
                            input bit pin, input t_rgba want);
        t_pix_case pc;
        pc.cfg = c;
        pc.px = '{bg, fg, mk};
        pc.pinned = pin;
        pc.want = want;
        directed_cases.push_back(pc);
    endtask

    // hold start until the word is taken
    task automatic push_pixel(input t_pix_in p, input bit pin, input t_rgba want);
        start <= 1'b1;
        drive_px <= p;
        pinned_en <= pin;
        pinned_val <= want;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding word come out
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (composite_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    // write all four registers back to back, one per edge
    task automatic apply_config(input t_cfg c);
        for (int n = 0; n < 4; n++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_reg_idx'(n);
            case (t_reg_idx'(n))
                REG_OPERATION:    i_cfg_wdata <= CFG_W'(c.op);
                REG_MIX:          i_cfg_wdata <= CFG_W'(c.mix);
                REG_MASK_CHANNEL: i_cfg_wdata <= CFG_W'(c.msel);
                default:          i_cfg_wdata <= CFG_W'(c.inv);
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result checking and expectation tracking, all on the rising edge
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_rgba want;
        t_rgba got;
        if (i_rst_n) begin
            // a result word is valid for the cycle ending at this edge
            if (o_strobe) begin
                got = '{o_out_red, o_out_green, o_out_blue, o_out_alpha};
                if (composite_due.size() == 0) begin
                    n_bad_words++;
                    if (n_bad_words <= 10) begin
                        $display("unexpected word: %h %h %h %h", got.r, got.g, got.b, got.a);
                    end
                end else begin
                    want = composite_due.pop_front();
                    if (got.r !== want.r || got.g !== want.g ||
                        got.b !== want.b || got.a !== want.a) begin
                        n_bad_words++;
                        if (n_bad_words <= 10) begin
                            $display("mismatch: want r %h g %h b %h a %h, got r %h g %h b %h a %h",
                                     want.r, want.g, want.b, want.a,
                                     got.r, got.g, got.b, got.a);
                        end
                    end
                end
            end
            // word taken at this edge, under the registers as they stand before any write
            if (start && !busy) begin
                composite_due.push_back(pinned_en ? pinned_val : blend_pixel(drive_px, live_cfg));
            end
            // shadow copy of the registers
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_OPERATION:    live_cfg.op = i_cfg_wdata[2:0];
                    REG_MIX:          live_cfg.mix = i_cfg_wdata[MIX_W-1:0];
                    REG_MASK_CHANNEL: live_cfg.msel = i_cfg_wdata[2:0];
                    default:          live_cfg.inv = i_cfg_wdata[0];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        t_cfg cur_cfg;
        t_cfg next_cfg;
        int   n_items;
        int   gap;
        bit   steady;

        cur_cfg = CFG_RESET;

        // all zero after reset: nothing moves
        add_case(CFG_RESET, '0, '0, '0, 1'b1, '0);
        // zero alpha mask: background passes through untouched
        add_case(CFG_RESET, '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
                 '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff},
                 '{16'h7fff, 16'h7fff, 16'h7fff, 16'h0000},
                 1'b1, '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        // negative coverage clamps to zero
        add_case(CFG_RESET, '{16'h8000, 16'h7fff, 16'h0000, 16'h7fff},
                 '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
                 '{16'h0000, 16'h0000, 16'h0000, 16'h8000},
                 1'b1, '{16'h8000, 16'h7fff, 16'h0000, 16'h7fff});
        // coverage far above one, composite saturating
        add_case(CFG_RESET, '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff},
                 '{16'h7fff, 16'h8000, 16'h7fff, 16'h7fff},
                 '{16'h0000, 16'h0000, 16'h0000, 16'h7fff}, 1'b0, '0);
        // over with unit alpha and full coverage gives the foreground
        add_case(CFG_FULL, '{16'h1234, 16'hf000, 16'h0800, 16'h0400},
                 '{16'h0c00, 16'h8000, 16'h7fff, 16'h1000},
                 '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
                 1'b1, '{16'h0c00, 16'h8000, 16'h7fff, 16'h1000});
        // plus target saturating both ways
        add_case('{OP_PLUS, ONE_MIX, MSK_NONE, 1'b0},
                 '{16'h7000, 16'h9000, 16'h0100, 16'h2345},
                 '{16'h7000, 16'h9000, 16'h0200, 16'h1000},
                 '{16'h1111, 16'h2222, 16'h3333, 16'h4444},
                 1'b1, '{16'h7fff, 16'h8000, 16'h0300, 16'h1000});
        add_case('{OP_MUL, ONE_MIX, MSK_NONE, 1'b0},
                 '{16'h0800, 16'h8000, 16'h7fff, 16'h0800},
                 '{16'h0800, 16'h7fff, 16'h7fff, 16'h0a00}, '0, 1'b0, '0);
        add_case('{OP_SCREEN, ONE_MIX, MSK_NONE, 1'b0},
                 '{16'h0c00, 16'h8000, 16'h7fff, 16'h1000},
                 '{16'h0400, 16'h8000, 16'h0000, 16'h0c00}, '0, 1'b0, '0);
        // difference across the whole range saturates
        add_case('{OP_DIFF, ONE_MIX, MSK_NONE, 1'b0},
                 '{16'h8000, 16'h1000, 16'h0000, 16'h0000},
                 '{16'h7fff, 16'h0800, 16'h0000, 16'h1000}, '0,
                 1'b1, '{16'h7fff, 16'h0800, 16'h0000, 16'h1000});
        add_case('{OP_DIFF, ONE_MIX, MSK_NONE, 1'b1},
                 '{16'h0300, 16'hf000, 16'h7000, 16'h0800},
                 '{16'h0900, 16'h0100, 16'h9000, 16'h0600},
                 '{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0);
        // spare operation codes act as over
        add_case('{OP_SPARE_LO, ONE_MIX, MSK_NONE, 1'b0},
                 '{16'h0100, 16'h0200, 16'h0300, 16'h0400},
                 '{16'h0a00, 16'hf800, 16'h0000, 16'h1000}, '0,
                 1'b1, '{16'h0a00, 16'hf800, 16'h0000, 16'h1000});
        add_case('{OP_SPARE_HI, ONE_MIX, MSK_NONE, 1'b0},
                 '{16'h0100, 16'h7fff, 16'h8000, 16'h0400},
                 '{16'h0a00, 16'h8000, 16'h7fff, 16'h0800}, '0, 1'b0, '0);
        // zero mix: background only
        add_case('{OP_PLUS, '0, MSK_NONE, 1'b0},
                 '{16'h7fff, 16'h8000, 16'h1234, 16'h0567},
                 '{16'h7fff, 16'h8000, 16'h7fff, 16'h7fff}, '0,
                 1'b1, '{16'h7fff, 16'h8000, 16'h1234, 16'h0567});
        // mix above one acts as one
        add_case('{OP_MUL, MIX_TOP, MSK_RED, 1'b0},
                 '{16'h0400, 16'hfc00, 16'h1800, 16'h0c00},
                 '{16'h1800, 16'h0800, 16'hf000, 16'h0900},
                 '{16'h0c00, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0);
        // spare mask codes mean full coverage
        add_case('{OP_OVER, ONE_MIX, MSK_SPARE_HI, 1'b0},
                 '{16'h7fff, 16'h8000, 16'h0000, 16'h0000},
                 '{16'h0300, 16'h0600, 16'h0900, 16'h1000}, '0,
                 1'b1, '{16'h0300, 16'h0600, 16'h0900, 16'h1000});
        add_case('{OP_SCREEN, MIX_W'(3000), MSK_SPARE_LO, 1'b1},
                 '{16'h0500, 16'h0a00, 16'h0f00, 16'h0400},
                 '{16'h0200, 16'h0c00, 16'h1200, 16'h0b00}, '0, 1'b0, '0);
        // inverted unit mask: no coverage
        add_case('{OP_SCREEN, ONE_MIX, MSK_GREEN, 1'b1},
                 '{16'h0400, 16'h0800, 16'h0c00, 16'h1000},
                 '{16'h0c00, 16'h0800, 16'h0400, 16'h0800},
                 '{16'h0000, 16'h1000, 16'h0000, 16'h0000},
                 1'b1, '{16'h0400, 16'h0800, 16'h0c00, 16'h1000});
        // inverted negative mask clamps to one
        add_case('{OP_SCREEN, ONE_MIX, MSK_BLUE, 1'b1},
                 '{16'h0400, 16'h8000, 16'h7fff, 16'h0200},
                 '{16'h0c00, 16'h7fff, 16'h8000, 16'h0e00},
                 '{16'h0000, 16'h0000, 16'h8000, 16'h0000}, 1'b0, '0);
        // composite alpha saturating to the minimum, with both alphas at either extreme
        add_case(CFG_FULL, '{16'h0100, 16'h0200, 16'h0300, 16'h7fff},
                 '{16'h0400, 16'h0500, 16'h0600, 16'h7fff}, '0, 1'b0, '0);
        add_case(CFG_FULL, '{16'h0100, 16'h0200, 16'h0300, 16'h8000},
                 '{16'h0400, 16'h0500, 16'h0600, 16'h8000}, '0, 1'b0, '0);
        // half mix, half coverage, half alpha
        add_case('{OP_OVER, MIX_W'(2048), MSK_ALPHA, 1'b0},
                 '{16'h0200, 16'h0e00, 16'hf400, 16'h0a00},
                 '{16'h0e00, 16'h0200, 16'h0c00, 16'h0800},
                 '{16'h0000, 16'h0000, 16'h0000, 16'h0800}, 1'b0, '0);
        add_case(CFG_RESET, '1, '1, '1, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, back to back; a new setting waits for an empty pipeline
        foreach (directed_cases[n]) begin
            if (directed_cases[n].cfg != cur_cfg) begin
                drain_pipeline();
                apply_config(directed_cases[n].cfg);
                cur_cfg = directed_cases[n].cfg;
            end
            push_pixel(directed_cases[n].px, directed_cases[n].pinned, directed_cases[n].want);
        end

        // random phases, each opened by a full drain so the sender waits on the pipe
        for (int ph = 0; ph < N_PHASES; ph++) begin
            next_cfg = phase_setting(ph);
            drain_pipeline();
            apply_config(next_cfg);
            steady = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(100, 140);
            for (int j = 0; j < n_items; j++) begin
                gap = steady ? 0 : pick_gap();
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                push_pixel(rand_pixel(), 1'b0, '0);
            end
        end

        drain_pipeline();
        repeat (4) @(posedge i_clk);
        if (n_bad_words == 0 && composite_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // guard against a hung pipeline
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: pixel_merge_blend.f
hdl/pmb_pkg.sv
hdl/pmb_target.sv
hdl/pmb_cover.sv
hdl/pmb_comp.sv
hdl/pmb_mix.sv
hdl/pixel_merge_blend.sv
verif/tb_pixel_merge_blend.sv
